### design/b64enc_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// No dependencies; the front, queue, back and top files use it by scoped names.
package b64enc_pkg;

	localparam logic [7:0] PAD_CHAR     = 8'h3D;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

	localparam logic [7:0] ALPHABET [64] = '{
		"A", "B", "C", "D", "E", "F", "G", "H", "I", "J", "K", "L", "M", "N", "O", "P",
		"Q", "R", "S", "T", "U", "V", "W", "X", "Y", "Z", "a", "b", "c", "d", "e", "f",
		"g", "h", "i", "j", "k", "l", "m", "n", "o", "p", "q", "r", "s", "t", "u", "v",
		"w", "x", "y", "z", "0", "1", "2", "3", "4", "5", "6", "7", "8", "9", "+", "/"
	};

	// One queued job: an optional group of four characters, then an optional newline.
	typedef struct packed {
		logic            has_quad;
		logic            has_nl;
		logic [3:0][7:0] quad;
	} job_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		return ALPHABET[v];
	endfunction

endpackage

### design/b64enc_ifs.sv
// Handshake channel interfaces: input byte items, output characters, configuration writes.
// No dependencies.
interface b64enc_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface b64enc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_of_run;

	modport source (output valid, out_char, last_of_run, input ready);
	modport sink (input valid, out_char, last_of_run, output ready);
endinterface

interface b64enc_cfg_if;
	logic valid;
	logic ready;
	logic line_wrap;

	modport source (output valid, line_wrap, input ready);
	modport sink (input valid, line_wrap, output ready);
endinterface

### design/b64enc_front.sv
// Front end: accepts byte items, holds partial groups, counts groups per line, builds jobs.
// Depends on b64enc_pkg and the channel interfaces in b64enc_ifs.sv.
module b64enc_front #(
	parameter int LINE_CHARS = 76
) (
	input  logic                clk,
	input  logic                arst_n,
	b64enc_item_if.sink         item,
	b64enc_cfg_if.sink          cfg,
	input  logic                q_full,
	output logic                push,
	output b64enc_pkg::job_t    job
);

	localparam int LINE_GROUPS = (LINE_CHARS + 3) / 4;
	localparam int GW          = $clog2(LINE_GROUPS + 1);

	logic          line_wrap_q;
	logic [7:0]    held0_q, held1_q;
	logic [1:0]    held_cnt_q;
	logic [GW-1:0] groups_q;

	logic [7:0]    held0_n, held1_n;
	logic [1:0]    held_cnt_n;
	logic [GW-1:0] groups_n;
	logic [GW-1:0] groups_inc;
	logic [7:0]    flush_c2;
	logic          fire;

	assign cfg.ready  = 1'b1;
	assign item.ready = !q_full;
	assign fire       = item.valid && item.ready;
	assign groups_inc = groups_q + 1'b1;

	always_comb begin
		held0_n    = held0_q;
		held1_n    = held1_q;
		held_cnt_n = held_cnt_q;
		groups_n   = groups_q;
		flush_c2   = 8'h00;
		job        = '0;
		if (item.has_byte && held_cnt_q == 2'd2) begin
			job.has_quad = 1'b1;
			job.quad[0]  = b64enc_pkg::b64_char(held0_q[7:2]);
			job.quad[1]  = b64enc_pkg::b64_char({held0_q[1:0], held1_q[7:4]});
			job.quad[2]  = b64enc_pkg::b64_char({held1_q[3:0], item.data_byte[7:6]});
			job.quad[3]  = b64enc_pkg::b64_char(item.data_byte[5:0]);
			held_cnt_n   = 2'd0;
			if (line_wrap_q) begin
				if (groups_inc >= GW'(LINE_GROUPS)) begin
					job.has_nl = 1'b1;
					groups_n   = '0;
				end else begin
					groups_n = groups_inc;
				end
			end
		end else if (item.has_byte) begin
			if (held_cnt_q[0]) begin
				held1_n = item.data_byte;
			end else begin
				held0_n = item.data_byte;
			end
			held_cnt_n = held_cnt_q + 2'd1;
		end
		if (item.end_of_message) begin
			flush_c2 = (held_cnt_n == 2'd2) ? held1_n : 8'h00;
			if (held_cnt_n != 2'd0) begin
				job.has_quad = 1'b1;
				job.quad[0]  = b64enc_pkg::b64_char(held0_n[7:2]);
				job.quad[1]  = b64enc_pkg::b64_char({held0_n[1:0], flush_c2[7:4]});
				job.quad[2]  = (held_cnt_n == 2'd2) ?
					b64enc_pkg::b64_char({flush_c2[3:0], 2'b00}) : b64enc_pkg::PAD_CHAR;
				job.quad[3]  = b64enc_pkg::PAD_CHAR;
			end
			if (line_wrap_q && (groups_n != '0 || held_cnt_n != 2'd0)) begin
				job.has_nl = 1'b1;
			end
			held0_n    = 8'h00;
			held1_n    = 8'h00;
			held_cnt_n = 2'd0;
			groups_n   = '0;
		end
	end

	assign push = fire && (job.has_quad || job.has_nl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_wrap_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			line_wrap_q <= cfg.line_wrap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held0_q    <= 8'h00;
			held1_q    <= 8'h00;
			held_cnt_q <= 2'd0;
			groups_q   <= '0;
		end else if (fire) begin
			held0_q    <= held0_n;
			held1_q    <= held1_n;
			held_cnt_q <= held_cnt_n;
			groups_q   <= groups_n;
		end
	end

endmodule

### design/b64enc_queue.sv
// Short job queue between front and back ends, so that each side stalls on its own.
// Depends on b64enc_pkg for the job type.
module b64enc_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64enc_pkg::job_t push_job,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output b64enc_pkg::job_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	b64enc_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/b64enc_back.sv
// Back end: walks jobs one character a cycle, unless stalled, into the registered output channel.
// Depends on b64enc_pkg and the character channel interface in b64enc_ifs.sv.
module b64enc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  b64enc_pkg::job_t head,
	output logic             pop,
	b64enc_char_if.source    chars
);

	localparam logic [2:0] NL_SLOT = 3'd4;

	logic            cur_valid_q;
	logic            cur_nl_q;
	logic [3:0][7:0] cur_quad_q;
	logic [2:0]      cur_idx_q;
	logic            out_valid_q;
	logic [7:0]      out_char_q;
	logic            out_last_q;

	logic            out_load;
	logic            emit;
	logic            emit_last;
	logic [7:0]      emit_char;

	assign out_load  = !out_valid_q || chars.ready;
	assign emit      = cur_valid_q && out_load;
	assign emit_last = (cur_idx_q == NL_SLOT) || (cur_idx_q == 3'd3 && !cur_nl_q);
	assign emit_char = (cur_idx_q == NL_SLOT) ?
		b64enc_pkg::NEWLINE_CHAR : cur_quad_q[cur_idx_q[1:0]];
	assign pop       = !empty && (!cur_valid_q || (emit && emit_last));

	assign chars.valid       = out_valid_q;
	assign chars.out_char    = out_char_q;
	assign chars.last_of_run = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_nl_q    <= 1'b0;
			cur_quad_q  <= '0;
			cur_idx_q   <= 3'd0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			cur_nl_q    <= head.has_nl;
			cur_quad_q  <= head.quad;
			cur_idx_q   <= head.has_quad ? 3'd0 : NL_SLOT;
		end else if (emit) begin
			if (emit_last) begin
				cur_valid_q <= 1'b0;
			end else begin
				cur_idx_q <= cur_idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= emit_char;
			out_last_q <= emit_last;
		end
	end

endmodule

### design/base64_stream_encoder.sv
// Streaming base64 encoder with optional line wrapping; top level joining front, queue, back.
// Path: each item's job passes through the queue, the current-job register and the output register.
// Throughput: one byte item per cycle into a QUEUE_DEPTH-entry job queue unless full; one character
// per cycle out unless stalled; 0 to 5 characters per item, about 1.33 per byte on average.
// Reset (arst_n low): clears held bytes, line count, queue and output; line_wrap returns to 1.
// Depends on b64enc_pkg, b64enc_ifs.sv, b64enc_front, b64enc_queue and b64enc_back.
module base64_stream_encoder #(
	parameter int LINE_CHARS  = 76,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	b64enc_item_if.sink   item,
	b64enc_char_if.source chars,
	b64enc_cfg_if.sink    cfg
);

	logic             q_full;
	logic             q_empty;
	logic             q_push;
	logic             q_pop;
	b64enc_pkg::job_t q_push_job;
	b64enc_pkg::job_t q_head;

	b64enc_front #(
		.LINE_CHARS(LINE_CHARS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.q_full (q_full),
		.push   (q_push),
		.job    (q_push_job)
	);

	b64enc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_push_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	b64enc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (q_empty),
		.head   (q_head),
		.pop    (q_pop),
		.chars  (chars)
	);

endmodule

### design/b64enc_checker.sv
// Port-level checks on the encoder's output channel, bound to the top level.
// Depends on base64_stream_encoder and the character channel interface.
module b64enc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_last
);

	localparam logic [7:0] NEWLINE = 8'h0A;

	a_quiet_after_reset: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("output valid on release of reset");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_char) && $stable(out_last))
		else $error("output payload changed while stalled");

	a_newline_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_char == NEWLINE |-> out_last)
		else $error("newline not marked as last of run");

endmodule

bind base64_stream_encoder b64enc_checker u_b64enc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (chars.valid),
	.out_ready (chars.ready),
	.out_char  (chars.out_char),
	.out_last  (chars.last_of_run)
);
